@@ rtl/core/nes_pkg.sv @@
// shared types, constants and lookup functions for the neuron euler step unit
// used by nes_exp2 and neuron_euler_step_unit; depends on nothing else
package nes_pkg;

   localparam int FRAC_BITS = 24;
   localparam int STATE_COUNT = 4;
   localparam int TERM_COUNT = 8;

   // exp2 result limit
   localparam logic [30:0] EXP_MAX = 31'h7fff_ffff;

   // configuration register indexes
   localparam logic [2:0] REG_SODIUM = 3'd0;
   localparam logic [2:0] REG_POTASSIUM = 3'd1;
   localparam logic [2:0] REG_LEAK = 3'd2;
   localparam logic [2:0] REG_SATURATION = 3'd3;
   localparam logic [2:0] REG_GATE = 3'd4;
   localparam logic [2:0] REG_TIME_STEP = 3'd5;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_OPX,
      ST_OPE1,
      ST_OPE2,
      ST_OPM,
      ST_OPW,
      ST_MAC,
      ST_DT0,
      ST_DT1,
      ST_DT2,
      ST_DT3,
      ST_OUT
   } state_type;

   // 23.253 offset in q11.24
   localparam logic signed [34:0] SAT_OFFSET = 35'sd390120604;

   // state values after reset
   function automatic logic signed [31:0] reset_value(input logic [1:0] idx);
      logic signed [31:0] v;
      unique case (idx)
         2'd0: v = -32'sd47494621;
         2'd1: v = 32'sd35804257;
         2'd2: v = -32'sd74339844;
         2'd3: v = -32'sd74339844;
      endcase
      return v;
   endfunction

   // 2^(k/16) with 20 fraction bits
   function automatic logic [21:0] exp_tab(input logic [4:0] k);
      logic [21:0] v;
      unique case (k)
         5'd0: v = 22'd1048576;
         5'd1: v = 22'd1095000;
         5'd2: v = 22'd1143480;
         5'd3: v = 22'd1194106;
         5'd4: v = 22'd1246974;
         5'd5: v = 22'd1302182;
         5'd6: v = 22'd1359835;
         5'd7: v = 22'd1420040;
         5'd8: v = 22'd1482910;
         5'd9: v = 22'd1548564;
         5'd10: v = 22'd1617125;
         5'd11: v = 22'd1688722;
         5'd12: v = 22'd1763488;
         5'd13: v = 22'd1841564;
         5'd14: v = 22'd1923097;
         5'd15: v = 22'd2008240;
         default: v = 22'd2097152;
      endcase
      return v;
   endfunction

   // derivative coefficient matrix, 20 fraction bits
   function automatic logic signed [28:0] rom(input logic [1:0] i, input logic [2:0] j);
      logic signed [28:0] v;
      unique case ({i, j})
         5'd0: v = 29'sd74224;
         5'd1: v = 29'sd21199;
         5'd2: v = 29'sd1394;
         5'd3: v = 29'sd2503762;
         5'd4: v = -29'sd25054180;
         5'd5: v = -29'sd9464707;
         5'd6: v = 29'sd141737;
         5'd7: v = -29'sd243384;
         5'd8: v = 29'sd74224;
         5'd9: v = 29'sd21199;
         5'd10: v = 29'sd1394;
         5'd11: v = 29'sd2503762;
         5'd12: v = -29'sd25054180;
         5'd13: v = -29'sd9464707;
         5'd14: v = 29'sd430617;
         5'd15: v = -29'sd243384;
         5'd16: v = 29'sd73044;
         5'd17: v = 29'sd20863;
         5'd18: v = 29'sd1372;
         5'd19: v = 29'sd4590230;
         5'd20: v = -29'sd45932664;
         5'd21: v = -29'sd9314320;
         5'd22: v = 29'sd139485;
         5'd23: v = 29'sd446204;
         5'd24: v = 29'sd68479;
         5'd25: v = 29'sd19559;
         5'd26: v = 29'sd1286;
         5'd27: v = 29'sd21587990;
         5'd28: v = -29'sd216022709;
         5'd29: v = -29'sd8732175;
         5'd30: v = 29'sd130767;
         5'd31: v = 29'sd24784587;
      endcase
      return v;
   endfunction

   // clamp to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/nes_exp2.sv @@
// two stage base-2 exponential: table lookup with interpolation, then shift
// depends on nes_pkg
module nes_exp2 (
   input  logic               clock,
   input  logic signed [34:0] x,
   output logic        [30:0] e
);

   logic signed [10:0] n_ff, n_in;
   logic [21:0] m_ff, m_in;
   logic [30:0] e_ff, e_in;

   // stage one: mantissa from table and linear interpolation
   always_comb begin
      logic [4:0] k;
      logic [21:0] lo, hi;
      logic [16:0] diff;
      logic [36:0] prod;
      k = {1'b0, x[23:20]};
      lo = nes_pkg::exp_tab(k);
      hi = nes_pkg::exp_tab(k + 5'd1);
      diff = 17'(hi - lo);
      prod = 37'(diff) * 37'(x[19:0]);
      m_in = lo + 22'(prod >> 20);
      n_in = x[34:24];
   end

   // stage two: scale by the integer part, saturate or flush
   always_comb begin
      logic signed [11:0] sh;
      logic [32:0] v;
      logic [4:0] rs;
      sh = 12'(n_ff) + 12'sd4;
      v = 33'(m_ff) << sh[3:0];
      rs = 5'(-sh);
      if (sh >= 12'sd11) begin
         e_in = nes_pkg::EXP_MAX;
      end else if (sh >= 12'sd0) begin
         e_in = (v > 33'(nes_pkg::EXP_MAX)) ? nes_pkg::EXP_MAX : v[30:0];
      end else if (sh <= -12'sd21) begin
         e_in = '0;
      end else begin
         e_in = 31'(m_ff >> rs);
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      m_ff <= m_in;
      e_ff <= e_in;
   end

   assign e = e_ff;

endmodule

@@ rtl/core/neuron_euler_step_unit.sv @@
// neuron euler step unit: sequencer, state and term memories, shared multipliers
// depends on nes_pkg and nes_exp2
//
// usage:
//   req channel: one beat per time tick, tdata[11:0] carries the signed input
//   current. rsp channel: one beat per tick with the four updated state
//   variables. csr channel: register writes, ready only while the unit is
//   idle, so a write never lands in the middle of a tick.
// sequence:
//   after a tick is accepted the sequencer reads the state memory, then
//   runs 10 exponential steps through the one two-stage exp2 unit and
//   coefficient multiplier, then for each of the four states a
//   multiply-accumulate over the term memory and the time step product,
//   which splits the step into two 12 bit halves, and finally loads the
//   output register. the next tick is taken only once the sequencer is back
//   in idle, so a tick is never accepted while another is in progress.
// reset:
//   the coefficients return to their defaults and the valid bits of the state
//   memory clear, so unwritten entries read the resting state.
// stalls:
//   the result sits in an output register; a new tick may be accepted while it
//   waits. if the previous result is still held when the next one finishes,
//   the sequencer waits in its last state.
module neuron_euler_step_unit (
   input  logic         clock,
   input  logic         reset,
   // fields: input_current[11:0], zero pad[15:12]
   input  logic [15:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // fields: membrane_out[31:0], second_out[63:32], third_out[95:64],
   // fourth_out[127:96]
   output logic [127:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam logic signed [65:0] ONE_Q = 66'sd16777216;

   nes_pkg::state_type state_ff, state_in;
   logic [3:0] cnt_ff;
   logic [3:0] op_ff;
   logic [1:0] i_ff;

   // configuration registers
   logic [30:0] sodium_ff, potassium_ff, leak_ff, saturation_ff, gate_ff;
   logic [23:0] time_step_ff;

   // memories
   logic [31:0] smem [4];
   logic [31:0] smem_q_ff;
   logic [3:0]  svld_ff;
   logic        rdv_ff;
   logic [1:0]  rda_ff;
   logic [31:0] tmem [8];
   logic [31:0] tmem_q_ff;

   // datapath
   logic signed [31:0] y_ff [4];
   logic signed [31:0] ns_ff [4];
   logic signed [31:0] ns_in_w;
   logic [11:0]        cur_ff;
   logic signed [34:0] x_ff, x_in;
   logic [30:0]        e;
   logic signed [65:0] p_ff;
   logic signed [31:0] u_ff;
   logic [30:0]        ea_ff;
   logic               rv_ff, pv_ff;
   logic [2:0]         jd_ff;
   logic signed [63:0] prod_ff, acc_ff;
   logic signed [39:0] d_ff;
   logic signed [52:0] plo_ff, phi_ff;
   logic [127:0]       rsp_data_ff;
   logic               rsp_valid_ff;

   logic        twe;
   logic [2:0]  twa;
   logic [31:0] twd;

   logic req_beat;
   assign req_tready = (state_ff == nes_pkg::ST_IDLE);
   assign req_beat = req_tvalid && req_tready;
   assign csr_ready = (state_ff == nes_pkg::ST_IDLE);
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   nes_exp2 u_exp (
      .clock (clock),
      .x     (x_ff),
      .e     (e)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nes_pkg::ST_IDLE: if (req_beat) state_in = nes_pkg::ST_LOAD;
         nes_pkg::ST_LOAD: if (cnt_ff == 4'd4) state_in = nes_pkg::ST_OPX;
         nes_pkg::ST_OPX:  state_in = nes_pkg::ST_OPE1;
         nes_pkg::ST_OPE1: state_in = nes_pkg::ST_OPE2;
         nes_pkg::ST_OPE2: state_in = nes_pkg::ST_OPM;
         nes_pkg::ST_OPM:  state_in = nes_pkg::ST_OPW;
         nes_pkg::ST_OPW:  state_in = (op_ff == 4'd9) ? nes_pkg::ST_MAC : nes_pkg::ST_OPX;
         nes_pkg::ST_MAC:  if (cnt_ff == 4'd9) state_in = nes_pkg::ST_DT0;
         nes_pkg::ST_DT0:  state_in = nes_pkg::ST_DT1;
         nes_pkg::ST_DT1:  state_in = nes_pkg::ST_DT2;
         nes_pkg::ST_DT2:  state_in = nes_pkg::ST_DT3;
         nes_pkg::ST_DT3:  state_in = (i_ff == 2'd3) ? nes_pkg::ST_OUT : nes_pkg::ST_MAC;
         nes_pkg::ST_OUT:  if (!rsp_valid_ff || rsp_tready) state_in = nes_pkg::ST_IDLE;
         default:          state_in = nes_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nes_pkg::ST_IDLE;
         cnt_ff <= '0;
         op_ff <= '0;
         i_ff <= '0;
         rsp_valid_ff <= 1'b0;
         svld_ff <= '0;
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= (state_in != state_ff) ? 4'd0 : cnt_ff + 4'd1;
         if (state_ff == nes_pkg::ST_LOAD) op_ff <= '0;
         else if (state_ff == nes_pkg::ST_OPW) op_ff <= op_ff + 4'd1;
         if (state_ff == nes_pkg::ST_LOAD) i_ff <= '0;
         else if (state_ff == nes_pkg::ST_DT3) i_ff <= i_ff + 2'd1;
         if (state_ff == nes_pkg::ST_DT3) svld_ff[i_ff] <= 1'b1;
         rv_ff <= (state_ff == nes_pkg::ST_MAC) && (cnt_ff < 4'd8);
         pv_ff <= rv_ff;
         if (state_ff == nes_pkg::ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sodium_ff <= 31'd305345;
         potassium_ff <= 31'd2288412;
         leak_ff <= 31'd122986224;
         saturation_ff <= 31'd110924193;
         gate_ff <= 31'd3823528;
         time_step_ff <= 24'd16777;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            nes_pkg::REG_SODIUM:     sodium_ff <= csr_data[30:0];
            nes_pkg::REG_POTASSIUM:  potassium_ff <= csr_data[30:0];
            nes_pkg::REG_LEAK:       leak_ff <= csr_data[30:0];
            nes_pkg::REG_SATURATION: saturation_ff <= csr_data[30:0];
            nes_pkg::REG_GATE:       gate_ff <= csr_data[30:0];
            nes_pkg::REG_TIME_STEP:  time_step_ff <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // state memory: read during load, written back after each time step
   always_ff @(posedge clock) begin
      if (state_ff == nes_pkg::ST_DT3) smem[i_ff] <= ns_in_w;
      smem_q_ff <= smem[cnt_ff[1:0]];
      rdv_ff <= svld_ff[cnt_ff[1:0]];
      rda_ff <= cnt_ff[1:0];
   end

   // capture current and states
   always_ff @(posedge clock) begin
      logic [1:0] yi;
      yi = 2'(cnt_ff - 4'd1);
      if (req_beat) cur_ff <= req_tdata[11:0];
      if (state_ff == nes_pkg::ST_LOAD && cnt_ff != 4'd0) begin
         y_ff[yi] <= rdv_ff ? smem_q_ff : nes_pkg::reset_value(rda_ff);
      end
   end

   // exp argument for each step
   always_comb begin
      logic signed [34:0] y0e, y1e, y2e, y3e, n1, n2, n3;
      y0e = 35'(y_ff[0]);
      y1e = 35'(y_ff[1]);
      y2e = 35'(y_ff[2]);
      y3e = 35'(y_ff[3]);
      n1 = (35'sd0 - 35'sd3 * y1e) >>> 2;
      n2 = (35'sd0 - 35'sd3 * y2e) >>> 2;
      n3 = (35'sd0 - 35'sd3 * y3e) >>> 2;
      unique case (op_ff)
         4'd0, 4'd1: x_in = y0e;
         4'd2:       x_in = n3;
         4'd3:       x_in = n2;
         4'd4:       x_in = 35'sd0 - y3e - nes_pkg::SAT_OFFSET;
         4'd5:       x_in = y0e + n1;
         4'd6:       x_in = n1;
         4'd7:       x_in = y1e;
         4'd8:       x_in = y2e;
         default:    x_in = y3e;
      endcase
   end

   // term memory write port
   always_comb begin
      logic signed [65:0] q;
      q = (p_ff + 66'sd8388608) >>> 24;
      twe = 1'b0;
      twa = '0;
      twd = '0;
      if (state_ff == nes_pkg::ST_LOAD && cnt_ff == 4'd0) begin
         twe = 1'b1;
         twd = 32'(signed'(cur_ff));
      end else if (state_ff == nes_pkg::ST_OPW) begin
         unique case (op_ff)
            4'd0: begin twe = 1'b1; twa = 3'd1; twd = nes_pkg::sat32(ONE_Q - q); end
            4'd2: begin twe = 1'b1; twa = 3'd2; twd = nes_pkg::sat32(q); end
            4'd3: begin twe = 1'b1; twa = 3'd3; twd = {1'b0, e}; end
            4'd4: begin twe = 1'b1; twa = 3'd4; twd = nes_pkg::sat32(ONE_Q - q); end
            4'd6: begin twe = 1'b1; twa = 3'd5; twd = nes_pkg::sat32(66'(ea_ff) - q); end
            4'd7: begin twe = 1'b1; twa = 3'd6; twd = nes_pkg::sat32(ONE_Q - q); end
            4'd9: begin
               twe = 1'b1;
               twa = 3'd7;
               twd = nes_pkg::sat32(66'(ea_ff) - 66'(e));
            end
            default: ;
         endcase
      end
   end

   // coefficient times exp multiplier and term steps
   always_ff @(posedge clock) begin
      logic signed [32:0] a, b;
      logic signed [65:0] q;
      q = (p_ff + 66'sd8388608) >>> 24;
      b = signed'({2'b00, e});
      unique case (op_ff)
         4'd0:    a = signed'({2'b00, leak_ff});
         4'd1:    a = signed'({2'b00, sodium_ff});
         4'd2:    a = 33'(u_ff);
         4'd4:    a = signed'({2'b00, saturation_ff});
         4'd6:    a = signed'({2'b00, potassium_ff});
         4'd7:    a = signed'({2'b00, gate_ff});
         default: a = '0;
      endcase
      if (state_ff == nes_pkg::ST_OPX) x_ff <= x_in;
      if (state_ff == nes_pkg::ST_OPM) p_ff <= a * b;
      if (state_ff == nes_pkg::ST_OPW) begin
         if (op_ff == 4'd1) u_ff <= nes_pkg::sat32(ONE_Q - q);
         if (op_ff == 4'd5 || op_ff == 4'd8) ea_ff <= e;
      end
      if (twe) tmem[twa] <= twd;
      tmem_q_ff <= tmem[cnt_ff[2:0]];
   end

   // multiply-accumulate over the terms
   always_ff @(posedge clock) begin
      logic signed [31:0] a;
      logic signed [60:0] m;
      a = (jd_ff == 3'd0) ? 32'(signed'(tmem_q_ff[11:0])) : signed'(tmem_q_ff);
      m = a * nes_pkg::rom(i_ff, jd_ff);
      jd_ff <= cnt_ff[2:0];
      prod_ff <= (jd_ff == 3'd0) ? (64'(m) <<< 24) : 64'(m);
      if (state_ff == nes_pkg::ST_MAC) begin
         if (cnt_ff == 4'd0) acc_ff <= '0;
         else if (pv_ff) acc_ff <= acc_ff + prod_ff;
      end
   end

   // time step product in two halves
   always_comb begin
      logic signed [63:0] sum, delta;
      sum = 64'(plo_ff) + (64'(phi_ff) <<< 12) + 64'sd8388608;
      delta = sum >>> 24;
      ns_in_w = nes_pkg::sat32(66'(y_ff[i_ff]) + 66'(delta));
   end

   always_ff @(posedge clock) begin
      logic signed [63:0] s;
      s = (acc_ff + 64'sd524288) >>> 20;
      if (state_ff == nes_pkg::ST_DT0) begin
         if (s > 64'sd549755813887) d_ff <= 40'sh7f_ffff_ffff;
         else if (s < -64'sd549755813888) d_ff <= 40'sh80_0000_0000;
         else d_ff <= s[39:0];
      end
      if (state_ff == nes_pkg::ST_DT1) plo_ff <= d_ff * signed'({1'b0, time_step_ff[11:0]});
      if (state_ff == nes_pkg::ST_DT2) phi_ff <= d_ff * signed'({1'b0, time_step_ff[23:12]});
      if (state_ff == nes_pkg::ST_DT3) ns_ff[i_ff] <= ns_in_w;
      if (state_ff == nes_pkg::ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {ns_ff[3], ns_ff[2], ns_ff[1], ns_ff[0]};
      end
   end

endmodule
